// ----- rtl/core/pbc_pkg.sv -----
// Shared constants and types for the predictor byte compressor.
// No dependencies; the emitter, the top level and the testbench import this package.
package pbc_pkg;

   localparam int GROUP_SIZE          = 8;
   localparam int GROUP_POS_BITS      = 3;
   localparam int LIT_COUNT_BITS      = 4;
   localparam int RESULT_POS_BITS     = 4;
   localparam int CONTEXT_BITS        = 16;
   localparam int EPOCH_BITS          = 4;
   localparam int DEF_TABLE_INDEX_BITS = 16;

   localparam logic [EPOCH_BITS-1:0]     EPOCH_MAX = {EPOCH_BITS{1'b1}};
   localparam logic [GROUP_POS_BITS-1:0] GROUP_LAST = GROUP_POS_BITS'(GROUP_SIZE - 1);

   // one finished group, handed from the predictor stage to the emitter
   typedef struct packed {
      logic [7:0]                      flag;
      logic [GROUP_SIZE-1:0][7:0]      lit;
      logic [LIT_COUNT_BITS-1:0]       count;
      logic                            close;  // trailing zero flag after a full last group
      logic                            final_grp;
   } pbc_group_type;

endpackage

// ----- rtl/core/pbc_if.sv -----
// Valid/ready channel interfaces for the compressor input and output.
// No dependencies.
interface pbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, data_byte, final_byte, input ready);
   modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface pbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_flag;
   logic       run_last;
   logic       stream_end;

   modport source (output valid, out_byte, is_flag, run_last, stream_end, input ready);
   modport sink   (input valid, out_byte, is_flag, run_last, stream_end, output ready);
endinterface

// ----- rtl/core/pbc_emitter.sv -----
// Output sequencer: holds one finished group and sends flag, literals and
// the optional closing flag. Depends on pbc_pkg and pbc_rsp_if.
module pbc_emitter
   import pbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pbc_group_type group_in,
   input  logic          load,
   output logic          can_load,
   pbc_rsp_if.source     rsp_chan
);

   logic                       valid_ff, valid_in;
   logic [RESULT_POS_BITS-1:0] pos_ff, pos_in;
   pbc_group_type              grp_ff, grp_in;

   logic [RESULT_POS_BITS-1:0] last_pos;
   logic [RESULT_POS_BITS-1:0] lit_pos;
   logic                       pop;
   logic                       at_last;

   assign last_pos = RESULT_POS_BITS'(grp_ff.count) + RESULT_POS_BITS'(grp_ff.close);
   assign lit_pos  = pos_ff - RESULT_POS_BITS'(1);
   assign pop      = valid_ff && rsp_chan.ready;
   assign at_last  = (pos_ff == last_pos);
   assign can_load = !valid_ff || (pop && at_last);

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      grp_in   = grp_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = '0;
         grp_in   = group_in;
      end else if (pop) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + RESULT_POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      grp_ff <= grp_in;
   end

   always_comb begin
      rsp_chan.valid = valid_ff;
      priority if (pos_ff == '0) begin
         rsp_chan.out_byte = grp_ff.flag;
         rsp_chan.is_flag  = 1'b1;
      end else if (pos_ff <= RESULT_POS_BITS'(grp_ff.count)) begin
         rsp_chan.out_byte = grp_ff.lit[lit_pos[GROUP_POS_BITS-1:0]];
         rsp_chan.is_flag  = 1'b0;
      end else begin
         rsp_chan.out_byte = 8'h00;
         rsp_chan.is_flag  = 1'b1;
      end
      rsp_chan.run_last   = at_last;
      rsp_chan.stream_end = at_last && grp_ff.final_grp;
   end

endmodule

// ----- rtl/core/predictor_byte_compressor.sv -----
// Top level of the predictor byte compressor: history table memory,
// predictor stage and group buffer. Depends on pbc_pkg, pbc_if, pbc_emitter.
//
//  channel    dir  payload                                   transaction
//  req_chan   in   data_byte[8], final_byte                  one stream byte
//  rsp_chan   out  out_byte[8], is_flag, run_last, stream_end one compressed byte
//
// Each byte reads the table at accept and writes it back when the predictor stage fires;
// a byte can be accepted every cycle when not stalled or clearing; a conflict on the same entry is forwarded.
// A group of eight produces 1 to 9 output bytes (10 at a full final group), so output bandwidth sets the rate.
// After reset, and after every 16th stream end, a clearing pass over all
// 2^TABLE_INDEX_BITS table entries blocks input; other stream ends use an epoch tag.
// A stalled output stops the predictor stage only when a second group is ready.
module predictor_byte_compressor
   import pbc_pkg::*;
#(
   parameter int TABLE_INDEX_BITS = DEF_TABLE_INDEX_BITS
) (
   input  logic      clock,
   input  logic      reset,
   pbc_req_if.sink   req_chan,
   pbc_rsp_if.source rsp_chan
);

   localparam int TABLE_DEPTH = 1 << TABLE_INDEX_BITS;
   localparam int ENTRY_BITS  = EPOCH_BITS + 8;

   // table memory: {epoch tag, byte}
   logic [ENTRY_BITS-1:0] table_mem [TABLE_DEPTH];
   logic [ENTRY_BITS-1:0] rd_ff;

   logic                        mem_we;
   logic [TABLE_INDEX_BITS-1:0] mem_waddr;
   logic [ENTRY_BITS-1:0]       mem_wdata;
   logic [TABLE_INDEX_BITS-1:0] rd_addr;

   logic [CONTEXT_BITS-1:0]     ctx_ff, ctx_in;
   logic [EPOCH_BITS-1:0]       epoch_ff, epoch_in;
   logic                        clear_ff, clear_in;
   logic [TABLE_INDEX_BITS-1:0] clear_addr_ff, clear_addr_in;

   logic                        s1_valid_ff, s1_valid_in;
   logic [7:0]                  s1_byte_ff;
   logic                        s1_final_ff;
   logic [TABLE_INDEX_BITS-1:0] s1_addr_ff;
   logic                        fwd_valid_ff;
   logic [7:0]                  fwd_byte_ff;

   logic [GROUP_POS_BITS-1:0]   pos_ff, pos_in;
   logic [7:0]                  flag_ff, flag_in;
   logic [LIT_COUNT_BITS-1:0]   lit_count_ff, lit_count_in;
   logic [GROUP_SIZE-1:0][7:0]  lit_ff, lit_new;

   logic                        req_fire;
   logic                        s1_fire;
   logic                        hit;
   logic                        full;
   logic                        need_flush;
   logic                        wrap_hold;
   logic [7:0]                  pred;
   logic [7:0]                  flag_new;
   logic [LIT_COUNT_BITS-1:0]   count_new;
   logic                        em_can_load;
   pbc_group_type               group_out;

   assign rd_addr = ctx_ff[TABLE_INDEX_BITS-1:0];

   // predictor stage
   assign pred = fwd_valid_ff ? fwd_byte_ff :
                 (rd_ff[ENTRY_BITS-1:8] == epoch_ff) ? rd_ff[7:0] : 8'h00;
   assign hit        = (pred == s1_byte_ff);
   assign full       = (pos_ff == GROUP_LAST);
   assign need_flush = full || s1_final_ff;
   assign s1_fire    = s1_valid_ff && (!need_flush || em_can_load);

   // a stream end that wraps the epoch must run the clearing pass first
   assign wrap_hold = s1_valid_ff && s1_final_ff && (epoch_ff == EPOCH_MAX);
   assign req_chan.ready = !clear_ff && (!s1_valid_ff || s1_fire) && !wrap_hold;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign flag_new  = flag_ff | (hit ? (8'd1 << pos_ff) : 8'd0);
   assign count_new = lit_count_ff + LIT_COUNT_BITS'(!hit);

   always_comb begin
      for (int j = 0; j < GROUP_SIZE; j++) begin
         if (!hit && (lit_count_ff[GROUP_POS_BITS-1:0] == GROUP_POS_BITS'(j))) begin
            lit_new[j] = s1_byte_ff;
         end else begin
            lit_new[j] = lit_ff[j];
         end
      end
   end

   always_comb begin
      group_out.flag      = flag_new;
      group_out.lit       = lit_new;
      group_out.count     = count_new;
      group_out.close     = full && s1_final_ff;
      group_out.final_grp = s1_final_ff;
   end

   // memory write port: clearing pass or predictor write-back
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = s1_addr_ff;
      mem_wdata = {epoch_ff, s1_byte_ff};
      if (clear_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_addr_ff;
         mem_wdata = {epoch_ff, 8'h00};
      end else if (s1_fire) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rd_ff <= table_mem[rd_addr];
      end
   end

   always_comb begin
      ctx_in        = ctx_ff;
      epoch_in      = epoch_ff;
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      s1_valid_in   = s1_valid_ff;
      pos_in        = pos_ff;
      flag_in       = flag_ff;
      lit_count_in  = lit_count_ff;

      if (req_fire) begin
         ctx_in = req_chan.final_byte ? '0 : {ctx_ff[7:0], req_chan.data_byte};
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + TABLE_INDEX_BITS'(1);
         if (clear_addr_ff == {TABLE_INDEX_BITS{1'b1}}) begin
            clear_in = 1'b0;
         end
      end

      if (s1_fire) begin
         if (need_flush) begin
            pos_in       = '0;
            flag_in      = '0;
            lit_count_in = '0;
         end else begin
            pos_in       = pos_ff + GROUP_POS_BITS'(1);
            flag_in      = flag_new;
            lit_count_in = count_new;
         end
         if (s1_final_ff) begin
            epoch_in = epoch_ff + EPOCH_BITS'(1);
            if (epoch_ff == EPOCH_MAX) begin
               clear_in      = 1'b1;
               clear_addr_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff        <= '0;
         epoch_ff      <= '0;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         pos_ff        <= '0;
         flag_ff       <= '0;
         lit_count_ff  <= '0;
      end else begin
         ctx_ff        <= ctx_in;
         epoch_ff      <= epoch_in;
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         pos_ff        <= pos_in;
         flag_ff       <= flag_in;
         lit_count_ff  <= lit_count_in;
         if (req_fire) begin
            // entry being written back this cycle: the read returns the old value
            fwd_valid_ff <= s1_valid_ff && !s1_final_ff && (s1_addr_ff == rd_addr);
         end
      end
      if (req_fire) begin
         s1_byte_ff  <= req_chan.data_byte;
         s1_final_ff <= req_chan.final_byte;
         s1_addr_ff  <= rd_addr;
         fwd_byte_ff <= s1_byte_ff;
      end
      if (s1_fire) begin
         lit_ff <= lit_new;
      end
   end

   pbc_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .group_in (group_out),
      .load     (s1_fire && need_flush),
      .can_load (em_can_load),
      .rsp_chan (rsp_chan)
   );

`ifndef ASSERT_OFF
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_chan.ready)
      else $error("input accepted during table clearing pass");

   a_epoch_step: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_final_ff) |=> (epoch_ff == $past(epoch_ff) + EPOCH_BITS'(1)))
      else $error("epoch did not advance at stream end");

   a_lit_count_bound: assert property (@(posedge clock) disable iff (reset)
      lit_count_ff <= LIT_COUNT_BITS'(pos_ff))
      else $error("literal count exceeds group position");

   a_flush_waits: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && need_flush && !em_can_load) |=> s1_valid_ff)
      else $error("group lost while emitter busy");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for predictor_byte_compressor: directed and random byte streams.
// Holds its own model of the history table, groups and flag bytes for the expected output.
// Depends on pbc_pkg, pbc_if and the compressor top level.
module testbench
   import pbc_pkg::*;
();

   localparam int TBL_BITS   = DEF_TABLE_INDEX_BITS;
   localparam int INDEX_MASK = (1 << TBL_BITS) - 1;
   // clearing passes over all 2^16 table entries after reset and every 16th stream end dominate
   localparam int LIMIT      = 3_000_000;
   localparam int SETTLE     = 32;
   localparam int RAND_ITEMS = 96;
   localparam int MAX_PRINT  = 20;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_flag;
      logic       run_last;
      logic       stream_end;
   } comp_byte_type;

   class compressor_scoreboard;
      bit [7:0]                history [int];
      bit [CONTEXT_BITS-1:0]   ctx;
      bit [GROUP_POS_BITS-1:0] gpos;
      bit [7:0]                hit_flags;
      bit [7:0]                literals [$];
      comp_byte_type           expected_q [$];
      int                      checked;

      function void push_expected(bit [7:0] b, bit flag, bit last_one, bit fin);
         comp_byte_type e;
         e.out_byte   = b;
         e.is_flag    = flag;
         e.run_last   = last_one;
         e.stream_end = last_one & fin;
         expected_q.push_back(e);
      endfunction

      // one accepted input transaction: predict, update table and group, queue the output
      function void note_input(bit [7:0] b, bit fin);
         int       idx;
         bit [7:0] predicted;
         bit       full;
         int       n;
         int       k;
         idx = int'(ctx) & INDEX_MASK;
         predicted = history.exists(idx) ? history[idx] : 8'h00;
         if (predicted == b)
            hit_flags[gpos] = 1'b1;
         else if (literals.size() < GROUP_SIZE)
            literals.push_back(b);
         history[idx] = b;
         ctx = {ctx[7:0], b};
         full = (gpos == GROUP_LAST);
         gpos = gpos + 1'b1;

         n = (full || fin) ? 1 + literals.size() + ((full && fin) ? 1 : 0) : 0;
         k = 0;
         if (full || fin) begin
            push_expected(hit_flags, 1'b1, k == n - 1, fin);
            k++;
            foreach (literals[j]) begin
               push_expected(literals[j], 1'b0, k == n - 1, fin);
               k++;
            end
            hit_flags = 8'h00;
            literals.delete();
         end
         if (full && fin)
            push_expected(8'h00, 1'b1, 1'b1, fin);
         if (fin) begin
            // each stream starts from a cleared table
            history.delete();
            ctx = '0;
            gpos = '0;
         end
      endfunction

      function bit check_result(comp_byte_type got, output string why);
         comp_byte_type e;
         why = "";
         if (expected_q.size() == 0) begin
            why = $sformatf("unexpected output byte %02h is_flag=%0d run_last=%0d end=%0d",
                            got.out_byte, got.is_flag, got.run_last, got.stream_end);
            return 1'b0;
         end
         e = expected_q.pop_front();
         checked++;
         if (got.out_byte != e.out_byte)
            why = {why, $sformatf(" out_byte %02h/%02h", got.out_byte, e.out_byte)};
         if (got.is_flag != e.is_flag)
            why = {why, $sformatf(" is_flag %0d/%0d", got.is_flag, e.is_flag)};
         if (got.run_last != e.run_last)
            why = {why, $sformatf(" run_last %0d/%0d", got.run_last, e.run_last)};
         if (got.stream_end != e.stream_end)
            why = {why, $sformatf(" stream_end %0d/%0d", got.stream_end, e.stream_end)};
         if (why != "") begin
            why = $sformatf("output %0d got/exp:%s", checked, why);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   pbc_req_if req_chan ();
   pbc_rsp_if rsp_chan ();

   predictor_byte_compressor #(.TABLE_INDEX_BITS(TBL_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   compressor_scoreboard sb = new();
   int  mismatches;
   int  bytes_sent;
   int  streams_sent;
   bit  req_steady;
   bit  rsp_steady;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("TIMEOUT after %0d cycles, %0d outputs still outstanding", LIMIT, sb.pending());
      $display("end of test: mismatches");
      $finish;
   end

   task automatic report(input string msg);
      if (mismatches < MAX_PRINT)
         $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // called at a rising edge; returns at the edge that accepts the transaction
   task automatic send_byte(input bit [7:0] b, input bit fin);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.final_byte <= fin;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_input(b, fin);
      bytes_sent++;
      if (fin) streams_sent++;
   endtask

   task automatic random_stream();
      int       len;
      int       mode;
      int       period;
      bit [7:0] pat [4];
      bit [7:0] b;
      int       r;
      r = $urandom_range(0, 9);
      if (r == 0)      len = $urandom_range(13, 30);
      else if (r < 3)  len = 8 * $urandom_range(1, 2);  // final byte closes a full group
      else             len = $urandom_range(1, 12);
      mode = $urandom_range(0, 9);
      period = $urandom_range(1, 4);
      foreach (pat[i]) pat[i] = 8'($urandom);
      req_steady = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
         if (mode >= 8)
            b = 8'($urandom_range(0, 255));
         else begin
            b = pat[i % period];
            if (mode >= 6 && $urandom_range(0, 4) == 0) b = 8'($urandom);
         end
         send_byte(b, i == len - 1);
      end
   endtask

   // output side: check accepted transactions, stall ready at random
   initial begin
      int            stall;
      comp_byte_type got;
      string         why;
      stall = 0;
      rsp_steady = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.out_byte   = rsp_chan.out_byte;
            got.is_flag    = rsp_chan.is_flag;
            got.run_last   = rsp_chan.run_last;
            got.stream_end = rsp_chan.stream_end;
            if (!sb.check_result(got, why)) report(why);
         end
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!rsp_steady && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
         if ($urandom_range(0, 299) == 0) rsp_steady = !rsp_steady;
      end
   end

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= 8'h00;
      req_chan.final_byte <= 1'b0;
      req_steady = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // single-byte streams: a hit on the cleared table, then a literal
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // a full final group of misses: eight literals and the closing zero flag
      for (int i = 0; i < 7; i++) send_byte(8'(i + 1), 1'b0);
      send_byte(8'h80, 1'b1);
      // all hits in a full final group
      for (int i = 0; i < 8; i++) send_byte(8'h00, i == 7);
      // repeated byte: misses until the context repeats, then hits
      for (int i = 0; i < 6; i++) send_byte(8'h5A, i == 5);

      while (bytes_sent < 24 + RAND_ITEMS) random_stream();
      req_chan.valid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.pending() > 0)
         report($sformatf("%0d expected outputs never arrived", sb.pending()));

      $display("Sent %0d bytes in %0d streams, checked %0d compressed bytes, %0d mismatches.",
               bytes_sent, streams_sent, sb.checked, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
